### sv/tctt_pkg.sv
// Shared types and constants for the connection timer table.
// No dependencies; imported by tctt_evt_out and tcp_connection_timer_table.
package tctt_pkg;

  localparam int unsigned TIME_W  = 30;
  localparam int unsigned SCAN_W  = 24;
  localparam int unsigned TWTO_W  = 30;
  localparam int unsigned RTINI_W = 29;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 30;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_ARM_TW     = 3'd1,
    OP_ARM_RT     = 3'd2,
    OP_RESTART_RT = 3'd3,
    OP_DISARM_RT  = 3'd4
  } tctt_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_INTERVAL    = 2'd0,
    REG_TIMEWAIT_TIMEOUT = 2'd1,
    REG_RETRANS_INITIAL  = 2'd2
  } tctt_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EVAL,
    ST_EMIT,
    ST_FLUSH
  } tctt_state_e;

  localparam logic KIND_TIMEWAIT = 1'b0;
  localparam logic KIND_RETRANS  = 1'b1;

  typedef struct packed {
    logic              push;
    logic              flush;
    logic [SLOT_W-1:0] slot;
    logic              kind;
  } tctt_evt_req_t;

endpackage

### sv/tctt_evt_out.sv
// Expiry event output stage: one held event plus the output register.
// The held event is released with tlast set when the scan flushes. Uses tctt_pkg.
module tctt_evt_out
  import tctt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tctt_evt_req_t req_i,
  output logic          req_ready_o,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [7:0]    m_axis_tdata_o,   // [3:0] expired_slot, [7:4] zero
  output logic          m_axis_tuser_o,   // [0] expiry_kind
  output logic          m_axis_tlast_o
);

  logic              hold_valid_q, hold_valid_d;
  logic [SLOT_W-1:0] hold_slot_q, hold_slot_d;
  logic              hold_kind_q, hold_kind_d;
  logic              out_valid_q, out_valid_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic              out_kind_q, out_kind_d;
  logic              out_last_q, out_last_d;
  logic              out_free;
  logic              take;

  assign out_free    = !out_valid_q || m_axis_tready_i;
  assign req_ready_o = !hold_valid_q || out_free;
  assign take        = (req_i.push || req_i.flush) && req_ready_o;

  always_comb begin
    hold_valid_d = hold_valid_q;
    hold_slot_d  = hold_slot_q;
    hold_kind_d  = hold_kind_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_slot_d   = out_slot_q;
    out_kind_d   = out_kind_q;
    out_last_d   = out_last_q;
    if (take) begin
      if (hold_valid_q) begin
        out_valid_d = 1'b1;
        out_slot_d  = hold_slot_q;
        out_kind_d  = hold_kind_q;
        out_last_d  = req_i.flush;
      end
      if (req_i.push) begin
        hold_valid_d = 1'b1;
        hold_slot_d  = req_i.slot;
        hold_kind_d  = req_i.kind;
      end else begin
        hold_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_slot_q <= hold_slot_d;
    hold_kind_q <= hold_kind_d;
    out_slot_q  <= out_slot_d;
    out_kind_q  <= out_kind_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_slot_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  a_no_push_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.push && req_i.flush))
    else $error("push and flush requested together");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.flush && req_ready_o) |=> !hold_valid_q)
    else $error("held event survived a flush");

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=>
      (out_valid_q && $stable({out_slot_q, out_kind_q, out_last_q})))
    else $error("output transaction changed while stalled");

endmodule

### sv/tcp_connection_timer_table.sv
// Connection timer table top level: command decode, tick scan and timer memories.
// Depends on tctt_pkg and tctt_evt_out.
// Arm, restart and disarm commands are accepted only in the idle state.
// A tick walks the slots through the timer memories (one read port each): every slot
//   passes through the read, evaluate and emit states, emit holding until each expiry
//   event of the slot is taken, and a flush state closes the scan.
// Reset clears the active bits and restores the register defaults; no clearing pass.
module tcp_connection_timer_table
  import tctt_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // [2:0] operation, [6:3] slot, [7] zero
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [7:0]           m_axis_tdata_o,   // [3:0] expired_slot, [7:4] zero
  output logic                 m_axis_tuser_o,   // [0] expiry_kind
  output logic                 m_axis_tlast_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  tctt_state_e          state_q, state_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 ev_tw_q, ev_tw_d;
  logic                 ev_rt_q, ev_rt_d;
  logic [SLOTS-1:0]     tw_act_q, tw_act_d;
  logic [SLOTS-1:0]     rt_act_q, rt_act_d;
  logic [SCAN_W-1:0]    scan_q;
  logic [TWTO_W-1:0]    twto_q;
  logic [RTINI_W-1:0]   rtini_q;

  logic [TIME_W-1:0]    tw_mem [SLOTS];
  logic [TIME_W-1:0]    rt_mem [SLOTS];
  logic [TIME_W-1:0]    tw_rdata_q, rt_rdata_q;

  logic                 in_acc;
  tctt_op_e             op;
  logic [SLOT_W-1:0]    cmd_slot;
  logic [IDX_W-1:0]     cmd_addr;
  logic                 slot_ok;
  logic                 tw_exp, rt_exp;
  logic [TIME_W-1:0]    scan_ext;
  logic                 rd_en;
  logic                 tw_we, rt_we;
  logic [IDX_W-1:0]     tw_waddr, rt_waddr;
  logic [TIME_W-1:0]    tw_wdata, rt_wdata;
  tctt_evt_req_t        evt_req;
  logic                 evt_ready;

  assign op       = tctt_op_e'(s_axis_tdata_i[2:0]);
  assign cmd_slot = s_axis_tdata_i[6:3];
  assign cmd_addr = IDX_W'(cmd_slot);
  assign slot_ok  = 32'(cmd_slot) < 32'(SLOTS);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign scan_ext = TIME_W'(scan_q);
  assign tw_exp   = tw_act_q[idx_q] && (tw_rdata_q <= scan_ext);
  assign rt_exp   = rt_act_q[idx_q] && (rt_rdata_q <= scan_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= SCAN_W'(1);
      twto_q  <= TWTO_W'(1000);
      rtini_q <= RTINI_W'(200);
    end else if (cfg_we_i) begin
      unique case (tctt_reg_e'(cfg_idx_i))
        REG_SCAN_INTERVAL:    scan_q  <= cfg_wdata_i[SCAN_W-1:0];
        REG_TIMEWAIT_TIMEOUT: twto_q  <= cfg_wdata_i[TWTO_W-1:0];
        REG_RETRANS_INITIAL:  rtini_q <= cfg_wdata_i[RTINI_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && op == OP_TICK) begin
          state_d = ST_RD;
          idx_d   = '0;
        end
      end
      ST_RD:   state_d = ST_EVAL;
      ST_EVAL: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!ev_tw_q && !ev_rt_q) begin
          if (idx_q == IDX_W'(SLOTS - 1)) begin
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_RD;
            idx_d   = idx_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (evt_ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    s_axis_tready_o = 1'b0;
    rd_en    = 1'b0;
    tw_we    = 1'b0;
    rt_we    = 1'b0;
    tw_waddr = idx_q;
    rt_waddr = idx_q;
    tw_wdata = tw_rdata_q - scan_ext;
    rt_wdata = rt_rdata_q - scan_ext;
    tw_act_d = tw_act_q;
    rt_act_d = rt_act_q;
    ev_tw_d  = ev_tw_q;
    ev_rt_d  = ev_rt_q;
    evt_req  = '{push: 1'b0, flush: 1'b0, slot: SLOT_W'(idx_q), kind: KIND_TIMEWAIT};
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (in_acc && slot_ok) begin
          tw_waddr = cmd_addr;
          rt_waddr = cmd_addr;
          tw_wdata = twto_q;
          rt_wdata = TIME_W'(rtini_q);
          case (op)
            OP_ARM_TW: begin
              tw_we              = 1'b1;
              tw_act_d[cmd_addr] = 1'b1;
            end
            OP_ARM_RT: begin
              rt_we              = 1'b1;
              rt_act_d[cmd_addr] = 1'b1;
            end
            OP_RESTART_RT: rt_we = 1'b1;
            OP_DISARM_RT:  rt_act_d[cmd_addr] = 1'b0;
            default: ;
          endcase
        end
      end
      ST_RD: rd_en = 1'b1;
      ST_EVAL: begin
        ev_tw_d = tw_exp;
        ev_rt_d = rt_exp;
        tw_we   = tw_act_q[idx_q];
        rt_we   = rt_act_q[idx_q];
        if (tw_exp) begin
          tw_wdata        = '0;
          tw_act_d[idx_q] = 1'b0;
        end
        if (rt_exp) begin
          rt_wdata = {rtini_q, 1'b0};
        end
      end
      ST_EMIT: begin
        evt_req.push = ev_tw_q || ev_rt_q;
        evt_req.kind = ev_tw_q ? KIND_TIMEWAIT : KIND_RETRANS;
        if (evt_ready && ev_tw_q) begin
          ev_tw_d = 1'b0;
        end else if (evt_ready && ev_rt_q) begin
          ev_rt_d = 1'b0;
        end
      end
      ST_FLUSH: evt_req.flush = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      ev_tw_q  <= 1'b0;
      ev_rt_q  <= 1'b0;
      tw_act_q <= '0;
      rt_act_q <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      ev_tw_q  <= ev_tw_d;
      ev_rt_q  <= ev_rt_d;
      tw_act_q <= tw_act_d;
      rt_act_q <= rt_act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tw_we) begin
      tw_mem[tw_waddr] <= tw_wdata;
    end
    if (rd_en) begin
      tw_rdata_q <= tw_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rt_we) begin
      rt_mem[rt_waddr] <= rt_wdata;
    end
    if (rd_en) begin
      rt_rdata_q <= rt_mem[idx_q];
    end
  end

  tctt_evt_out u_evt_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (evt_req),
    .req_ready_o     (evt_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> ($past(state_q) == ST_RD))
    else $error("evaluation without a preceding memory read");

  a_flags_clear_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> (!ev_tw_q && !ev_rt_q))
    else $error("pending expiry lost when advancing to next slot");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tw_we || rt_we) |-> (state_q == ST_IDLE || state_q == ST_EVAL))
    else $error("timer memory written outside command or evaluate phase");

endmodule

### tb/tb_top.sv
// Self-checking bench for tcp_connection_timer_table: drives commands and ticks on the input
// stream, tracks a shadow timer table and checks every expiry event on the output stream.
// Depends on tctt_pkg and the timer table RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tctt_pkg::*;

  localparam int unsigned NSLOT        = 16;
  localparam int unsigned DRAIN_CYCLES = 4 * NSLOT + 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED      = 2'd3;
  localparam logic [OP_W-1:0]      OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_W-1:0]      OP_LAST_UNUSED  = 3'd7;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              kind;
    logic              last;
  } expiry_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [7:0]           s_axis_tdata_i = '0;   // [2:0] operation, [6:3] slot, [7] zero
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [7:0]           m_axis_tdata_o;        // [3:0] expired_slot, [7:4] zero
  logic                 m_axis_tuser_o;        // [0] expiry_kind
  logic                 m_axis_tlast_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  logic [SCAN_W-1:0]  scan_step;
  logic [TWTO_W-1:0]  timewait_load;
  logic [RTINI_W-1:0] retrans_load;
  bit                 timewait_on[NSLOT];
  logic [31:0]        timewait_left[NSLOT];
  bit                 retrans_on[NSLOT];
  logic [31:0]        retrans_left[NSLOT];

  expiry_t     pending_expiries[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned events_checked = 0;
  int unsigned commands_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned cycle_count = 0;

  tcp_connection_timer_table #(.SLOTS(NSLOT)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d events outstanding", cycle_count,
               pending_expiries.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void note_mismatch(string what, expiry_t want, expiry_t got);
    if (mismatch_count < 10) begin
      $display("%0t %s: expected slot %0d kind %0d last %0d, got slot %0d kind %0d last %0d",
               $realtime, what, want.slot, want.kind, want.last, got.slot, got.kind, got.last);
    end
    mismatch_count++;
  endfunction

  always @(posedge clk_i) begin : check_events
    expiry_t got;
    expiry_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = expiry_t'{slot: m_axis_tdata_o[SLOT_W-1:0], kind: m_axis_tuser_o,
                      last: m_axis_tlast_o};
      events_checked++;
      if (pending_expiries.size() == 0) begin
        note_mismatch("unexpected event", '0, got);
      end else begin
        want = pending_expiries.pop_front();
        if (got.slot !== want.slot || got.kind !== want.kind || got.last !== want.last) begin
          note_mismatch("event mismatch", want, got);
        end
      end
    end
  end

  function automatic void reset_timer_table();
    scan_step     = 24'd1;
    timewait_load = 30'd1000;
    retrans_load  = 29'd200;
    for (int i = 0; i < NSLOT; i++) begin
      timewait_on[i]   = 1'b0;
      timewait_left[i] = '0;
      retrans_on[i]    = 1'b0;
      retrans_left[i]  = '0;
    end
  endfunction

  function automatic void apply_command(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot);
    expiry_t burst[$];
    case (op)
      OP_TICK: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (timewait_on[i]) begin
            if (timewait_left[i] <= 32'(scan_step)) begin
              timewait_on[i]   = 1'b0;
              timewait_left[i] = '0;
              burst.push_back(expiry_t'{slot: SLOT_W'(i), kind: KIND_TIMEWAIT, last: 1'b0});
            end else begin
              timewait_left[i] -= 32'(scan_step);
            end
          end
          if (retrans_on[i]) begin
            if (retrans_left[i] <= 32'(scan_step)) begin
              retrans_left[i] = 32'(retrans_load) << 1;
              burst.push_back(expiry_t'{slot: SLOT_W'(i), kind: KIND_RETRANS, last: 1'b0});
            end else begin
              retrans_left[i] -= 32'(scan_step);
            end
          end
        end
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        foreach (burst[k]) pending_expiries.push_back(burst[k]);
        ticks_sent++;
      end
      OP_ARM_TW: begin
        timewait_on[slot]   = 1'b1;
        timewait_left[slot] = 32'(timewait_load);
      end
      OP_ARM_RT: begin
        retrans_on[slot]   = 1'b1;
        retrans_left[slot] = 32'(retrans_load);
      end
      OP_RESTART_RT: retrans_left[slot] = 32'(retrans_load);
      OP_DISARM_RT:  retrans_on[slot] = 1'b0;
      default: ;
    endcase
  endfunction

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, slot, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    commands_sent++;
    apply_command(op, slot);
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_expiries.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_SCAN_INTERVAL:    scan_step     = value[SCAN_W-1:0];
      REG_TIMEWAIT_TIMEOUT: timewait_load = value[TWTO_W-1:0];
      REG_RETRANS_INITIAL:  retrans_load  = value[RTINI_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_end();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [CFG_W-1:0] scan, input logic [CFG_W-1:0] tw,
                           input logic [CFG_W-1:0] rt);
    wait_idle();
    cfg_write(REG_SCAN_INTERVAL, scan);
    cfg_write(REG_TIMEWAIT_TIMEOUT, tw);
    cfg_write(REG_RETRANS_INITIAL, rt);
    cfg_end();
  endtask

  task automatic test_reset_defaults();
    send_cmd(OP_FIRST_UNUSED, 4'd0);
    send_cmd(OP_LAST_UNUSED, 4'd15);
    send_cmd(OP_DISARM_RT, 4'd4);
    send_cmd(OP_RESTART_RT, 4'd3);
    send_cmd(OP_TICK, 4'd15);
    send_cmd(OP_ARM_TW, 4'd0);
    send_cmd(OP_ARM_RT, 4'd15);
    send_cmd(OP_ARM_RT, 4'd15);
    send_cmd(OP_TICK, 4'd9);
    send_cmd(OP_DISARM_RT, 4'd15);
  endtask

  task automatic test_short_timers();
    wait_idle();
    cfg_write(REG_SCAN_INTERVAL, 30'd1);
    cfg_write(REG_TIMEWAIT_TIMEOUT, 30'd2);
    cfg_write(REG_RETRANS_INITIAL, 30'd1);
    cfg_write(REG_UNUSED, '1);
    cfg_end();
    send_cmd(OP_ARM_TW, 4'd0);
    send_cmd(OP_ARM_RT, 4'd0);
    send_cmd(OP_ARM_TW, 4'd15);
    send_cmd(OP_ARM_RT, 4'd9);
    repeat (3) send_cmd(OP_TICK, 4'd0);
    send_cmd(OP_ARM_RT, 4'd0);
    send_cmd(OP_RESTART_RT, 4'd9);
    send_cmd(OP_DISARM_RT, 4'd0);
    send_cmd(OP_TICK, 4'd7);
  endtask

  task automatic test_zero_registers();
    configure(30'd0, 30'd1, 30'd0);
    send_cmd(OP_ARM_RT, 4'd5);
    send_cmd(OP_ARM_TW, 4'd6);
    send_cmd(OP_RESTART_RT, 4'd3);
    repeat (2) send_cmd(OP_TICK, 4'd0);
    configure(30'd3, 30'd1, 30'd0);
    send_cmd(OP_TICK, 4'd0);
    send_cmd(OP_DISARM_RT, 4'd5);
    send_cmd(OP_DISARM_RT, 4'd9);
    send_cmd(OP_TICK, 4'd0);
  endtask

  task automatic test_register_extremes();
    configure('1, '1, '1);
    send_cmd(OP_ARM_TW, 4'd1);
    send_cmd(OP_ARM_RT, 4'd2);
    repeat (3) send_cmd(OP_TICK, 4'd0);
    send_cmd(OP_DISARM_RT, 4'd2);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input bit wide_values, input int unsigned count);
    int unsigned scan;
    int unsigned tw;
    int unsigned rt;
    int unsigned pick;
    int unsigned issued;
    logic [OP_W-1:0] op;
    if (wide_values) begin
      scan = $urandom_range(24'hFFFFFF, 24'h800000);
      tw   = scan * $urandom_range(6, 0) + $urandom_range(scan, 0);
      rt   = scan * $urandom_range(3, 0) + $urandom_range(scan, 0);
    end else begin
      scan = $urandom_range(6, 1);
      tw   = $urandom_range(30, 1);
      rt   = $urandom_range(12, 1);
    end
    configure(CFG_W'(scan), CFG_W'(tw), CFG_W'(rt));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    issued = 0;
    while (issued < count) begin
      pick = $urandom_range(99);
      if (pick < 35)      op = OP_TICK;
      else if (pick < 55) op = OP_ARM_TW;
      else if (pick < 72) op = OP_ARM_RT;
      else if (pick < 82) op = OP_RESTART_RT;
      else if (pick < 93) op = OP_DISARM_RT;
      else                op = OP_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
      send_cmd(op, SLOT_W'($urandom_range(NSLOT - 1)));
      if (op <= OP_DISARM_RT) issued++;
    end
  endtask

  initial begin
    reset_timer_table();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_short_timers();
    test_zero_registers();
    test_register_extremes();
    test_random_traffic(0, 0, 1'b0, 125);
    test_random_traffic(65, 0, 1'b1, 125);
    test_random_traffic(0, 65, 1'b0, 125);
    test_random_traffic(36, 36, 1'b1, 125);
    wait_idle();
    $display("Covered %0d commands (%0d ticks) under four register settings and idle patterns;",
             commands_sent, ticks_sent);
    $display("checked %0d expiry events in %0d cycles", events_checked, cycle_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
sv/tctt_pkg.sv
sv/tctt_evt_out.sv
sv/tcp_connection_timer_table.sv
tb/tb_top.sv
